FILE: design/swcc_pkg.sv
// ---------------------------------------------------------------------------
// swcc_pkg
// shared widths, codes, reset values and word types of the window manager
// ---------------------------------------------------------------------------
package swcc_pkg;

	localparam int SEQ_W      = 32;
	localparam int WIN_W      = 12;
	localparam int ACC_W      = 13;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 3;

	// largest window the design will ever hold
	localparam int WINDOW_LIMIT = 4095;

	// event codes
	localparam logic [OP_W-1:0] OP_SEND     = 2'd0;
	localparam logic [OP_W-1:0] OP_ACK      = 2'd1;
	localparam logic [OP_W-1:0] OP_TIMEOUT  = 2'd2;
	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_GRANT  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ADV    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOPROG = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RESEND = 3'd4;
	localparam logic [STATUS_W-1:0] ST_CLOSED = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WINDOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_FLOOR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_CEILING    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_WINDOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PEER_WINDOW_START = 3'd5;

	// register values after reset
	localparam logic [WIN_W-1:0] RST_INITIAL_WINDOW    = 12'd3;
	localparam logic [WIN_W-1:0] RST_INITIAL_THRESHOLD = 12'd64;
	localparam logic [WIN_W-1:0] RST_THRESHOLD_FLOOR   = 12'd32;
	localparam logic [WIN_W-1:0] RST_WINDOW_CEILING    = 12'd3000;
	localparam logic [WIN_W-1:0] RST_TIMEOUT_WINDOW    = 12'd200;
	localparam logic [WIN_W-1:0] RST_PEER_WINDOW_START = 12'd1024;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [SEQ_W-1:0] ack_number;
		logic [WIN_W-1:0] advertised_window;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SEQ_W-1:0]    seq_number;
		logic [WIN_W-1:0]    slot_index;
		logic [WIN_W-1:0]    item_count;
		logic [WIN_W-1:0]    window_now;
		logic [WIN_W-1:0]    threshold_now;
		logic                restart_timer;
	} rsp_t;

	// live configuration seen by the engine
	typedef struct packed {
		logic [WIN_W-1:0] threshold_floor;
		logic [WIN_W-1:0] window_ceiling;
		logic [WIN_W-1:0] timeout_window;
	} cfg_t;

endpackage

FILE: design/swcc_if.sv
// ---------------------------------------------------------------------------
// swcc interfaces
// valid/ready channels for event words, result words and register writes
// ---------------------------------------------------------------------------
interface swcc_req_if;
	import swcc_pkg::*;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [SEQ_W-1:0] ack_number;
	logic [WIN_W-1:0] advertised_window;

	modport source (output valid, opcode, ack_number, advertised_window, input ready);
	modport sink (input valid, opcode, ack_number, advertised_window, output ready);
endinterface

interface swcc_rsp_if;
	import swcc_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SEQ_W-1:0]    seq_number;
	logic [WIN_W-1:0]    slot_index;
	logic [WIN_W-1:0]    item_count;
	logic [WIN_W-1:0]    window_now;
	logic [WIN_W-1:0]    threshold_now;
	logic                restart_timer;

	modport source (output valid, status, seq_number, slot_index, item_count, window_now,
		threshold_now, restart_timer, input ready);
	modport sink (input valid, status, seq_number, slot_index, item_count, window_now,
		threshold_now, restart_timer, output ready);
endinterface

interface swcc_cfg_if;
	import swcc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WIN_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/sliding_window_congestion_control.sv
// ---------------------------------------------------------------------------
// sliding_window_congestion_control
// go-back-n sender window manager with slow start congestion window
// ---------------------------------------------------------------------------
// result path: an event word taken goes into the input register, and one pass
//   of the update loads the result register, where the result word becomes valid;
//   a waiting result that is not taken holds the event in the input register
// throughput: one event word per cycle while the result register is free or being taken
// reset: arst_n clears all control state at once; window state and registers
//   take their default values, no clearing pass is needed
module sliding_window_congestion_control (
	input  logic        clk,
	input  logic        arst_n,
	swcc_req_if.sink    req,
	swcc_rsp_if.source  rsp,
	swcc_cfg_if.sink    cfg
);
	import swcc_pkg::*;

	// input register stage
	req_t req_s1;
	logic valid_s1;

	// result register
	rsp_t rsp_q;
	logic rsp_valid_q;

	cfg_t cfg_val;
	rsp_t eng_rsp;
	logic advance;

	// the staged event is processed whenever the result register is free or
	// being emptied this cycle, so a waiting result that is not taken stops the
	// input side from refilling its own register while that register is full
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.opcode            <= req.opcode;
			req_s1.ack_number        <= req.ack_number;
			req_s1.advertised_window <= req.advertised_window;
		end
	end

	// register file for the limits used by the update
	swcc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_val (cfg_val)
	);

	// window state and the per-event update
	swcc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.cfg    (cfg_val),
		.rsp    (eng_rsp)
	);

	// result word holds until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= eng_rsp;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_q.status;
	assign rsp.seq_number    = rsp_q.seq_number;
	assign rsp.slot_index    = rsp_q.slot_index;
	assign rsp.item_count    = rsp_q.item_count;
	assign rsp.window_now    = rsp_q.window_now;
	assign rsp.threshold_now = rsp_q.threshold_now;
	assign rsp.restart_timer = rsp_q.restart_timer;

endmodule

FILE: design/swcc_cfg.sv
// ---------------------------------------------------------------------------
// swcc_cfg
// configuration register file, always ready for a write
// ---------------------------------------------------------------------------
module swcc_cfg (
	input  logic            clk,
	input  logic            arst_n,
	swcc_cfg_if.sink        cfg,
	output swcc_pkg::cfg_t  cfg_val
);
	import swcc_pkg::*;

	logic [WIN_W-1:0] floor_q;
	logic [WIN_W-1:0] ceiling_q;
	logic [WIN_W-1:0] timeout_q;

	assign cfg.ready = 1'b1;

	// initial window, threshold and peer window only seed state at reset,
	// and reset restores their defaults as well, so those writes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q   <= RST_THRESHOLD_FLOOR;
			ceiling_q <= RST_WINDOW_CEILING;
			timeout_q <= RST_TIMEOUT_WINDOW;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_THRESHOLD_FLOOR: floor_q   <= cfg.data;
				CFG_WINDOW_CEILING:  ceiling_q <= cfg.data;
				CFG_TIMEOUT_WINDOW:  timeout_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg_val.threshold_floor = floor_q;
	assign cfg_val.window_ceiling  = ceiling_q;
	assign cfg_val.timeout_window  = timeout_q;

endmodule

FILE: design/swcc_engine.sv
// ---------------------------------------------------------------------------
// swcc_engine
// sender window state and the update for one event word
// ---------------------------------------------------------------------------
module swcc_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  swcc_pkg::req_t  req,
	input  swcc_pkg::cfg_t  cfg,
	output swcc_pkg::rsp_t  rsp
);
	import swcc_pkg::*;

	localparam int               CAP_INT = (WINDOW_LIMIT > 4095) ? 4095 : WINDOW_LIMIT;
	localparam logic [WIN_W-1:0] WIN_CAP = WIN_W'(CAP_INT);
	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	function automatic logic [WIN_W-1:0] win_cap(input logic [WIN_W:0] v);
		return (v > {1'b0, WIN_CAP}) ? WIN_CAP : v[WIN_W-1:0];
	endfunction

	// cw + n limited to the ceiling, n may be far wider than a window
	function automatic logic [WIN_W-1:0] grow_add(input logic [WIN_W-1:0] cw,
		input logic [SEQ_W-1:0] n, input logic [WIN_W-1:0] ceil);
		logic [WIN_W:0] s;
		s = {1'b0, cw} + {1'b0, n[WIN_W-1:0]};
		if ((|n[SEQ_W-1:WIN_W]) || (s > {1'b0, ceil}))
			s = {1'b0, ceil};
		return win_cap(s);
	endfunction

	localparam logic [WIN_W-1:0] RST_CW = win_cap({1'b0, RST_INITIAL_WINDOW});

	logic [SEQ_W-1:0] base_q, base_d, next_q, next_d, hi_q, hi_d;
	logic [WIN_W-1:0] cw_q, cw_d, thr_q, thr_d, latch_q, latch_d, peer_q, peer_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic [1:0]       dup_q, dup_d;
	logic             closed_q, closed_d;

	logic [SEQ_W-1:0] outst, hi_new, n;
	logic [WIN_W-1:0] thr_half, thr_ack, cw_send, cw_to, latch_new;
	logic [ACC_W-1:0] acc_first, acc_add, acc_new;
	logic [ACC_W:0]   acc_sum;
	logic [1:0]       dup_inc;
	logic             dup3, advanced, round_done;

	// shared pieces of the update
	assign outst    = next_q - base_q - SEQ_W'(1);
	assign thr_half = (thr_q >= cfg.threshold_floor) ? (thr_q >> 1) : thr_q;
	assign hi_new   = ((hi_q != '0) && (req.ack_number == '0)) ? '0 :
		(req.ack_number > hi_q) ? req.ack_number : hi_q;
	assign dup_inc  = (req.ack_number < hi_new) ? dup_q + 2'd1 : dup_q;
	assign dup3     = (dup_inc == 2'd3);
	assign thr_ack  = dup3 ? thr_half : thr_q;
	assign advanced = (hi_new > base_q);
	assign n        = hi_new - base_q;
	assign cw_send  = (peer_q < cw_q) ? peer_q : cw_q;
	assign cw_to    = win_cap({1'b0, cfg.timeout_window});

	// congestion avoidance accumulator, saturating
	assign acc_first  = (|n[SEQ_W-1:ACC_W]) ? ACC_MAX : n[ACC_W-1:0];
	assign acc_sum    = {1'b0, acc_q} + {1'b0, n[ACC_W-1:0]};
	assign acc_add    = ((|n[SEQ_W-1:ACC_W]) || acc_sum[ACC_W]) ? ACC_MAX : acc_sum[ACC_W-1:0];
	assign latch_new  = (latch_q == '0) ? cw_q : latch_q;
	assign acc_new    = (latch_q == '0) ? acc_first : acc_add;
	assign round_done = (acc_new >= {1'b0, latch_new});

	always_comb begin
		base_d   = base_q;
		next_d   = next_q;
		hi_d     = hi_q;
		cw_d     = cw_q;
		thr_d    = thr_q;
		latch_d  = latch_q;
		peer_d   = peer_q;
		acc_d    = acc_q;
		dup_d    = dup_q;
		closed_d = closed_q;

		rsp.status        = ST_NOPROG;
		rsp.seq_number    = '0;
		rsp.slot_index    = '0;
		rsp.item_count    = '0;
		rsp.restart_timer = 1'b0;

		if (closed_q) begin
			rsp.status = ST_CLOSED;
		end else begin
			unique case (req.opcode)
				OP_SEND: begin
					cw_d = cw_send;
					if (outst < {{(SEQ_W-WIN_W){1'b0}}, cw_send}) begin
						rsp.status     = ST_GRANT;
						rsp.seq_number = next_q;
						rsp.slot_index = outst[WIN_W-1:0];
						next_d         = next_q + SEQ_W'(1);
					end else begin
						rsp.status = ST_FULL;
					end
				end
				OP_ACK: begin
					hi_d  = hi_new;
					thr_d = thr_ack;
					dup_d = dup3 ? 2'd0 : dup_inc;
					if (peer_q != '0)
						peer_d = req.advertised_window;
					if (advanced) begin
						if (cw_q < thr_ack) begin
							cw_d = grow_add(cw_q, n, cfg.window_ceiling);
						end else if (round_done) begin
							acc_d   = '0;
							latch_d = '0;
							cw_d    = grow_add(cw_q, SEQ_W'(1), cfg.window_ceiling);
						end else begin
							acc_d   = acc_new;
							latch_d = latch_new;
						end
						base_d            = hi_new;
						rsp.status        = ST_ADV;
						rsp.item_count    = (|n[SEQ_W-1:WIN_W]) ? '1 : n[WIN_W-1:0];
						rsp.restart_timer = 1'b1;
					end else if ((hi_new == '0) && (base_q != '0)) begin
						closed_d   = 1'b1;
						rsp.status = ST_CLOSED;
					end else begin
						rsp.status        = ST_NOPROG;
						rsp.restart_timer = 1'b1;
					end
				end
				OP_TIMEOUT: begin
					thr_d          = thr_half;
					cw_d           = cw_to;
					rsp.item_count = (outst < {{(SEQ_W-WIN_W){1'b0}}, cw_to}) ?
						outst[WIN_W-1:0] : cw_to;
					rsp.seq_number = base_q + SEQ_W'(1);
					rsp.status     = ST_RESEND;
				end
				OP_RESERVED: ;
			endcase
		end

		rsp.window_now    = cw_d;
		rsp.threshold_now = thr_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			next_q   <= SEQ_W'(1);
			hi_q     <= '0;
			cw_q     <= RST_CW;
			thr_q    <= RST_INITIAL_THRESHOLD;
			latch_q  <= '0;
			peer_q   <= RST_PEER_WINDOW_START;
			acc_q    <= '0;
			dup_q    <= '0;
			closed_q <= 1'b0;
		end else if (step) begin
			base_q   <= base_d;
			next_q   <= next_d;
			hi_q     <= hi_d;
			cw_q     <= cw_d;
			thr_q    <= thr_d;
			latch_q  <= latch_d;
			peer_q   <= peer_d;
			acc_q    <= acc_d;
			dup_q    <= dup_d;
			closed_q <= closed_d;
		end
	end

	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q)
		else $error("closed sender reopened");

	a_grant_bumps_seq: assert property (@(posedge clk) disable iff (!arst_n)
		step && (rsp.status == ST_GRANT) |=> next_q == $past(next_q) + SEQ_W'(1))
		else $error("grant did not advance next sequence number");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(base_q) && $stable(next_q) && $stable(cw_q))
		else $error("window state moved without an event");

	a_adv_moves_base: assert property (@(posedge clk) disable iff (!arst_n)
		step && (rsp.status == ST_ADV) |=> base_q != $past(base_q))
		else $error("ack advance left base unchanged");

endmodule
